[src/nsc_pkg.sv]
package nsc_pkg;

    localparam int DEFAULT_LINE_BYTES = 128;
    localparam int HDR_BYTES = 6;
    localparam int LEN_W = 7;
    localparam int MIN_LINE = 9;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [23:0] TYPE_GGA = "GGA";
    localparam logic [23:0] TYPE_RMC = "RMC";
    localparam logic [23:0] TYPE_GSA = "GSA";
    localparam logic [23:0] TYPE_GSV = "GSV";

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_FRAMING  = 3'd2,
        ST_HEX      = 3'd3,
        ST_MISMATCH = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        KIND_OTHER = 3'd0,
        KIND_GGA   = 3'd1,
        KIND_RMC   = 3'd2,
        KIND_GSA   = 3'd3,
        KIND_GSV   = 3'd4
    } t_kind;

    typedef struct packed {
        t_status          status;
        t_kind            kind;
        logic [7:0]       talker_hi;
        logic [7:0]       talker_lo;
        logic [LEN_W-1:0] line_length;
        logic [7:0]       computed_sum;
        logic [31:0]      passed_count;
        logic [31:0]      failed_count;
    } t_result;

    // {bad, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

[src/nmea_sentence_checker_top.sv]
// NMEA 0183 sentence checker.
// Input channel: one received byte per word on i_rx_byte, qualified by
// i_in_valid; the block holds it off with o_in_stall.
// Output channel: one result word per closed or overflowed line (status,
// sentence kind, talker, length, computed checksum, pass/fail totals),
// qualified by o_out_valid; the receiver holds it with i_out_stall.
// Bytes that open a line, extend it, or arrive with no line open give
// no result word.
// A byte in the input register updates the line state when it passes to
// the core, and its result word, if any, enters the output register at that same edge.
// Throughput: one byte per cycle while the output is not stalled; the
// input register and the output register carry one word each.
// Stall: while a result word waits under i_out_stall, the byte in the
// input register waits too and o_in_stall rises once that register is full.
// Reset (synchronous, active low): no line open, totals cleared, both
// registers empty.
module nmea_sentence_checker_top import nsc_pkg::*; #(
    parameter int LINE_BYTES = DEFAULT_LINE_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_status,
    output logic [2:0] o_sentence_kind,
    output logic [7:0] o_talker_hi,
    output logic [7:0] o_talker_lo,
    output logic [6:0] o_line_length,
    output logic [7:0] o_computed_sum,
    output logic [31:0] o_passed_count,
    output logic [31:0] o_failed_count
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_free;
    logic       fire;
    logic       emit;
    t_result    core_res;
    t_result    out_res;

    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    nsc_core #(
        .LINE_BYTES(LINE_BYTES)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (fire),
        .i_byte (r_in_byte),
        .o_emit (emit),
        .o_res  (core_res)
    );

    nsc_out_reg u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (fire),
        .i_emit (emit),
        .i_res  (core_res),
        .i_stall(i_out_stall),
        .o_free (out_free),
        .o_valid(o_out_valid),
        .o_res  (out_res)
    );

    assign o_status        = out_res.status;
    assign o_sentence_kind = out_res.kind;
    assign o_talker_hi     = out_res.talker_hi;
    assign o_talker_lo     = out_res.talker_lo;
    assign o_line_length   = out_res.line_length;
    assign o_computed_sum  = out_res.computed_sum;
    assign o_passed_count  = out_res.passed_count;
    assign o_failed_count  = out_res.failed_count;

endmodule

[src/nsc_core.sv]
module nsc_core import nsc_pkg::*; #(
    parameter int LINE_BYTES = DEFAULT_LINE_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output logic       o_emit,
    output t_result    o_res
);

    localparam int FW = $clog2(LINE_BYTES);

    logic [FW-1:0] r_fill, n_fill;
    logic          r_star, n_star;
    logic [1:0]    r_tail, n_tail;
    logic [7:0]    r_xor, n_xor;
    logic          r_zero, n_zero;
    logic [7:0]    r_hex_hi, n_hex_hi;
    logic [7:0]    r_hex_lo, n_hex_lo;
    logic [7:0]    r_hdr [HDR_BYTES];
    logic [7:0]    n_hdr [HDR_BYTES];
    logic [31:0]   r_pass, n_pass;
    logic [31:0]   r_fail, n_fail;

    logic [FW+LEN_W-1:0] fill_ext;
    logic [4:0]          hv_hi, hv_lo;
    logic [23:0]         type_chars;
    t_status             chk_status;
    t_kind               chk_kind;

    assign fill_ext   = {{LEN_W{1'b0}}, r_fill};
    assign hv_hi      = hex_digit(r_hex_hi);
    assign hv_lo      = hex_digit(r_hex_lo);
    assign type_chars = {r_hdr[2], r_hdr[3], r_hdr[4]};

    always_comb begin
        chk_kind = KIND_OTHER;
        if (!r_star || r_tail != 2'd2 || r_fill < FW'(MIN_LINE) || r_hdr[5] != CH_COMMA) begin
            chk_status = ST_FRAMING;
        end else if (hv_hi[4] || hv_lo[4]) begin
            chk_status = ST_HEX;
        end else if (r_xor != {hv_hi[3:0], hv_lo[3:0]}) begin
            chk_status = ST_MISMATCH;
        end else begin
            chk_status = ST_OK;
            if (type_chars == TYPE_GGA) begin
                chk_kind = KIND_GGA;
            end else if (type_chars == TYPE_RMC) begin
                chk_kind = KIND_RMC;
            end else if (type_chars == TYPE_GSA) begin
                chk_kind = KIND_GSA;
            end else if (type_chars == TYPE_GSV) begin
                chk_kind = KIND_GSV;
            end
        end
    end

    always_comb begin
        n_fill   = r_fill;
        n_star   = r_star;
        n_tail   = r_tail;
        n_xor    = r_xor;
        n_zero   = r_zero;
        n_hex_hi = r_hex_hi;
        n_hex_lo = r_hex_lo;
        n_hdr    = r_hdr;
        n_pass   = r_pass;
        n_fail   = r_fail;
        o_emit   = 1'b0;

        o_res.status       = chk_status;
        o_res.kind         = chk_kind;
        o_res.talker_hi    = r_hdr[0];
        o_res.talker_lo    = r_hdr[1];
        o_res.line_length  = fill_ext[LEN_W-1:0];
        o_res.computed_sum = r_xor;
        o_res.passed_count = r_pass;
        o_res.failed_count = r_fail;

        if (i_fire) begin
            if (i_byte == CH_DOLLAR) begin
                n_fill   = FW'(1);
                n_star   = 1'b0;
                n_tail   = 2'd0;
                n_xor    = 8'h00;
                n_zero   = 1'b0;
                n_hex_hi = 8'h00;
                n_hex_lo = 8'h00;
                for (int k = 0; k < HDR_BYTES; k++) begin
                    n_hdr[k] = 8'h00;
                end
            end else if (r_fill != '0) begin
                if (i_byte == CH_CR || i_byte == CH_LF) begin
                    o_emit = 1'b1;
                    n_fill = '0;
                    if (chk_status == ST_OK) begin
                        n_pass = r_pass + 32'd1;
                    end else begin
                        n_fail = r_fail + 32'd1;
                    end
                    o_res.passed_count = n_pass;
                    o_res.failed_count = n_fail;
                end else if (r_fill >= FW'(LINE_BYTES - 1)) begin
                    o_emit             = 1'b1;
                    n_fill             = '0;
                    n_fail             = r_fail + 32'd1;
                    o_res.status       = ST_OVERFLOW;
                    o_res.kind         = KIND_OTHER;
                    o_res.failed_count = n_fail;
                end else begin
                    for (int k = 0; k < HDR_BYTES; k++) begin
                        if (r_fill == FW'(k + 1)) begin
                            n_hdr[k] = i_byte;
                        end
                    end
                    n_fill = r_fill + FW'(1);
                    if (!r_zero) begin
                        if (i_byte == CH_NUL) begin
                            n_zero = 1'b1;
                        end else if (!r_star) begin
                            if (i_byte == CH_STAR) begin
                                n_star = 1'b1;
                            end else begin
                                n_xor = r_xor ^ i_byte;
                            end
                        end else begin
                            if (r_tail == 2'd0) begin
                                n_hex_hi = i_byte;
                            end else if (r_tail == 2'd1) begin
                                n_hex_lo = i_byte;
                            end
                            if (r_tail != 2'd3) begin
                                n_tail = r_tail + 2'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_star   <= 1'b0;
            r_tail   <= 2'd0;
            r_xor    <= 8'h00;
            r_zero   <= 1'b0;
            r_hex_hi <= 8'h00;
            r_hex_lo <= 8'h00;
            for (int k = 0; k < HDR_BYTES; k++) begin
                r_hdr[k] <= 8'h00;
            end
            r_pass   <= 32'd0;
            r_fail   <= 32'd0;
        end else begin
            r_fill   <= n_fill;
            r_star   <= n_star;
            r_tail   <= n_tail;
            r_xor    <= n_xor;
            r_zero   <= n_zero;
            r_hex_hi <= n_hex_hi;
            r_hex_lo <= n_hex_lo;
            r_hdr    <= n_hdr;
            r_pass   <= n_pass;
            r_fail   <= n_fail;
        end
    end

endmodule

[src/nsc_out_reg.sv]
module nsc_out_reg import nsc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_emit,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load && i_emit) begin
            r_res <= i_res;
        end
    end

endmodule

[tb/tb_top.sv]
module tb_top;
    import nsc_pkg::*;

    localparam int LINE_MAX = DEFAULT_LINE_BYTES;

    typedef logic [7:0] t_octets[$];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic [2:0]  o_sentence_kind;
    logic [7:0]  o_talker_hi;
    logic [7:0]  o_talker_lo;
    logic [6:0]  o_line_length;
    logic [7:0]  o_computed_sum;
    logic [31:0] o_passed_count;
    logic [31:0] o_failed_count;

    // line state of the checker, mirrored
    int unsigned line_fill = 0;
    bit          star_seen = 1'b0;
    int unsigned tail_n = 0;
    logic [7:0]  xor_acc = 8'h00;
    bit          nul_seen = 1'b0;
    logic [7:0]  hex_hi = 8'h00;
    logic [7:0]  hex_lo = 8'h00;
    logic [7:0]  hdr [6] = '{default: 8'h00};
    logic [31:0] n_pass = 32'd0;
    logic [31:0] n_fail = 32'd0;

    t_result     pending_verdicts[$];
    t_result     want;
    int unsigned bytes_sent = 0;
    int unsigned n_errors = 0;
    bit          gaps_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned stall_pick;

    nmea_sentence_checker_top #(
        .LINE_BYTES(LINE_MAX)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_sentence_kind(o_sentence_kind),
        .o_talker_hi    (o_talker_hi),
        .o_talker_lo    (o_talker_lo),
        .o_line_length  (o_line_length),
        .o_computed_sum (o_computed_sum),
        .o_passed_count (o_passed_count),
        .o_failed_count (o_failed_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    function automatic void track_byte(input logic [7:0] c);
        t_result v;
        int h, l;
        if (c == CH_DOLLAR) begin
            line_fill = 1;
            star_seen = 1'b0;
            tail_n = 0;
            xor_acc = 8'h00;
            nul_seen = 1'b0;
            hex_hi = 8'h00;
            hex_lo = 8'h00;
            hdr = '{default: 8'h00};
            return;
        end
        if (line_fill == 0) return;
        if (c == CH_CR || c == CH_LF || line_fill >= LINE_MAX - 1) begin
            v.kind = KIND_OTHER;
            if (c != CH_CR && c != CH_LF) begin
                v.status = ST_OVERFLOW;
            end else if (!star_seen || tail_n != 2 || line_fill < MIN_LINE ||
                         hdr[5] != CH_COMMA) begin
                v.status = ST_FRAMING;
            end else begin
                h = nibble_of(hex_hi);
                l = nibble_of(hex_lo);
                if (h < 0 || l < 0) begin
                    v.status = ST_HEX;
                end else if (xor_acc != 8'(h * 16 + l)) begin
                    v.status = ST_MISMATCH;
                end else begin
                    v.status = ST_OK;
                    case ({hdr[2], hdr[3], hdr[4]})
                        TYPE_GGA: v.kind = KIND_GGA;
                        TYPE_RMC: v.kind = KIND_RMC;
                        TYPE_GSA: v.kind = KIND_GSA;
                        TYPE_GSV: v.kind = KIND_GSV;
                        default:  v.kind = KIND_OTHER;
                    endcase
                end
            end
            if (v.status == ST_OK) n_pass++;
            else n_fail++;
            v.talker_hi = hdr[0];
            v.talker_lo = hdr[1];
            v.line_length = 7'(line_fill);
            v.computed_sum = xor_acc;
            v.passed_count = n_pass;
            v.failed_count = n_fail;
            pending_verdicts.push_back(v);
            line_fill = 0;
            return;
        end
        if (line_fill <= 6) hdr[line_fill - 1] = c;
        line_fill++;
        if (nul_seen) return;
        if (c == CH_NUL) begin
            nul_seen = 1'b1;
        end else if (!star_seen) begin
            if (c == CH_STAR) star_seen = 1'b1;
            else xor_acc ^= c;
        end else begin
            if (tail_n == 0) hex_hi = c;
            else if (tail_n == 1) hex_lo = c;
            if (tail_n < 3) tail_n++;
        end
    endfunction

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) begin
            report($sformatf("%s: got %0h, expected %0h", name, got, exp_val));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                report("result word with no line pending");
            end else begin
                want = pending_verdicts.pop_front();
                check_field("status", o_status, want.status);
                check_field("sentence_kind", o_sentence_kind, want.kind);
                check_field("talker_hi", o_talker_hi, want.talker_hi);
                check_field("talker_lo", o_talker_lo, want.talker_lo);
                check_field("line_length", o_line_length, want.line_length);
                check_field("computed_sum", o_computed_sum, want.computed_sum);
                check_field("passed_count", o_passed_count, want.passed_count);
                check_field("failed_count", o_failed_count, want.failed_count);
            end
        end
    end

    // output backpressure: mostly short stalls, a few long, some clean stretches
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 8) begin
                i_out_stall <= 1'b0;
                stall_left = $urandom_range(30, 80);
            end else if (stall_pick < 55) begin
                i_out_stall <= 1'b0;
                stall_left = $urandom_range(1, 6);
            end else if (stall_pick < 92) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(1, 3);
            end else begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end else begin
            stall_left--;
        end
    end

    task automatic send_byte(input logic [7:0] c);
        int unsigned r, gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (gaps_on && r >= 55) gap = (r < 92) ? $urandom_range(1, 3) : $urandom_range(6, 25);
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rx_byte <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_byte(c);
        bytes_sent++;
    endtask

    task automatic send_seq(input t_octets s);
        foreach (s[i]) send_byte(s[i]);
    endtask

    task automatic send_line(input t_octets s, input logic [7:0] term);
        send_seq(s);
        send_byte(term);
    endtask

    function automatic t_octets txt(input string t);
        t_octets q;
        for (int i = 0; i < t.len(); i++) q.push_back(t[i]);
        return q;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 10) return 8'("0" + v);
        return 8'((lower ? "a" : "A") + v - 10);
    endfunction

    // payload bytes that neither frame nor end the checksummed part
    function automatic t_octets filler(input int n);
        t_octets q;
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            do c = 8'($urandom_range(1, 255));
            while (c == CH_DOLLAR || c == CH_CR || c == CH_LF || c == CH_STAR);
            q.push_back(c);
        end
        return q;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (nibble_of(c) >= 0 || c == CH_DOLLAR || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] letter();
        return 8'($urandom_range("A", "Z"));
    endfunction

    // '$' talker type ',' body '*' hh, checksum xored with flip
    function automatic t_octets sentence(input logic [15:0] talker, input logic [23:0] kind3,
                                         input t_octets body, input logic [7:0] flip,
                                         input bit lower);
        t_octets s;
        logic [7:0] cks;
        s = {CH_DOLLAR, talker[15:8], talker[7:0], kind3[23:16], kind3[15:8], kind3[7:0],
             CH_COMMA};
        foreach (body[i]) s.push_back(body[i]);
        cks = 8'h00;
        for (int i = 1; i < s.size(); i++) cks ^= s[i];
        cks ^= flip;
        s.push_back(CH_STAR);
        s.push_back(hex_char(cks[7:4], lower));
        s.push_back(hex_char(cks[3:0], lower));
        return s;
    endfunction

    function automatic t_octets rand_sentence(input logic [7:0] flip, input int body_len);
        logic [23:0] kind3;
        case ($urandom_range(0, 4))
            0: kind3 = TYPE_GGA;
            1: kind3 = TYPE_RMC;
            2: kind3 = TYPE_GSA;
            3: kind3 = TYPE_GSV;
            default: kind3 = {letter(), letter(), letter()};
        endcase
        return sentence({letter(), letter()}, kind3, filler(body_len), flip,
                        1'($urandom_range(0, 1)));
    endfunction

    task automatic test_idle_bytes();
        t_octets s;
        gaps_on = 1'b1;
        s = {CH_NUL, 8'hFF, CH_STAR, CH_CR, CH_LF, 8'h80, CH_COMMA};
        send_seq(s);
    endtask

    task automatic test_sentence_kinds();
        gaps_on = 1'b1;
        send_line(sentence("GP", TYPE_GGA, txt("123519,4807.038,N,01131.000,E"), 8'h00, 1'b0),
                  CH_CR);
        send_line(sentence("GN", TYPE_RMC, txt("225446,A,4916.45,N"), 8'h00, 1'b1), CH_LF);
        send_line(sentence("GP", TYPE_GSA, txt("A,3,04,05"), 8'h00, 1'b0), CH_CR);
        send_line(sentence("GL", TYPE_GSV, txt("2,1,08"), 8'h00, 1'b1), CH_LF);
        send_line(sentence("GP", "ZDA", txt("201530.00,04,07"), 8'h00, 1'b1), CH_CR);
        send_line(sentence(16'hFF80, TYPE_GGA, txt(""), 8'h00, 1'b0), CH_CR);
    endtask

    task automatic test_checksum_errors();
        t_octets s;
        gaps_on = 1'b1;
        send_line(sentence("GP", TYPE_GGA, txt("1,2"), 8'h5A, 1'b0), CH_CR);
        s = sentence("GP", TYPE_RMC, txt("A"), 8'h00, 1'b0);
        s[s.size() - 2] = "G";
        send_line(s, CH_CR);
        s[s.size() - 2] = "/";
        s[s.size() - 1] = "g";
        send_line(s, CH_CR);
        s[s.size() - 2] = "@";
        s[s.size() - 1] = ":";
        send_line(s, CH_LF);
    endtask

    task automatic test_framing_errors();
        t_octets s;
        gaps_on = 1'b1;
        send_line(txt("$"), CH_CR);
        send_line(txt("$GPGGA,1234"), CH_LF);
        send_line(txt("$GP*00"), CH_CR);
        s = sentence("GP", TYPE_GGA, txt("9"), 8'h00, 1'b0);
        send_line(s[0:s.size() - 2], CH_CR);
        s.push_back("7");
        send_line(s, CH_CR);
        s.push_back("7");
        send_line(s, CH_LF);
        s = sentence("GP", TYPE_GGA, txt("9"), 8'h00, 1'b0);
        s[6] = ";";
        send_line(s, CH_CR);
    endtask

    task automatic test_zero_byte();
        t_octets s;
        gaps_on = 1'b1;
        s = txt("$GPGGA,12*00");
        s.insert(7, CH_NUL);
        send_line(s, CH_CR);
        s = sentence("GP", TYPE_GSA, txt("1,2,3"), 8'h00, 1'b1);
        s.push_back(CH_NUL);
        s.push_back("Z");
        send_line(s, CH_CR);
        s = sentence("GP", TYPE_GSA, txt("1,2,3"), 8'h00, 1'b0);
        s.insert(s.size() - 1, CH_NUL);
        send_line(s, CH_LF);
        s = sentence("GP", TYPE_RMC, txt("4"), 8'h00, 1'b0);
        s.insert(1, CH_NUL);
        send_line(s, CH_CR);
    endtask

    task automatic test_restart();
        gaps_on = 1'b1;
        send_seq(txt("$GPGG"));
        send_line(sentence("GP", TYPE_GSV, txt("1,1"), 8'h00, 1'b0), CH_CR);
    endtask

    task automatic test_line_limit();
        t_octets s;
        gaps_on = 1'b0;
        send_line(sentence("GP", TYPE_RMC, filler(LINE_MAX - 11), 8'h00, 1'b0), CH_CR);
        s = filler(LINE_MAX - 2);
        s.push_front(CH_DOLLAR);
        send_line(s, CH_CR);
        s = filler(LINE_MAX);
        s.push_front(CH_DOLLAR);
        send_line(s, CH_CR);
    endtask

    task automatic test_random_traffic();
        t_octets s;
        int unsigned r, b0;
        logic [7:0] c;
        b0 = bytes_sent;
        while (bytes_sent - b0 < 200) begin
            gaps_on = ($urandom_range(0, 7) != 0);
            r = $urandom_range(0, 99);
            s = rand_sentence((r >= 50 && r < 58) ? 8'($urandom_range(1, 255)) : 8'h00,
                              $urandom_range(0, 16));
            if (r >= 58 && r < 65) begin
                s[s.size() - 1 - $urandom_range(0, 1)] = non_hex();
            end else if (r >= 65 && r < 71) begin
                if ($urandom_range(0, 1)) s.delete(s.size() - 1);
                else repeat ($urandom_range(1, 3)) s.push_back(hex_char(4'($urandom), 1'b0));
            end else if (r >= 71 && r < 75) begin
                s.insert($urandom_range(1, s.size()), CH_NUL);
            end else if (r >= 75 && r < 79) begin
                c = non_hex();
                if ($urandom_range(0, 1)) s[6] = (c == CH_COMMA) ? ";" : c;
                else s = s[0:$urandom_range(0, 7)];
            end else if (r >= 79 && r < 83) begin
                send_seq(s[0:$urandom_range(0, s.size() - 2)]);
            end else if (r >= 83 && r < 86) begin
                s = s[0:s.size() - 4];
            end else if (r >= 86 && r < 94) begin
                s.delete();
                repeat ($urandom_range(1, 8)) s.push_back(8'($urandom));
            end else if (r >= 94 && r < 96) begin
                s = filler(LINE_MAX - 1 + $urandom_range(0, 2));
                s.push_front(CH_DOLLAR);
            end else if (r >= 96 && r < 98) begin
                s = rand_sentence(8'h00, LINE_MAX - 11);
            end else if (r >= 98) begin
                s = txt("$");
            end
            if (r < 86 || r >= 94 || $urandom_range(0, 1)) begin
                s.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
            end
            send_seq(s);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_bytes();
        test_sentence_kinds();
        test_checksum_errors();
        test_framing_errors();
        test_zero_byte();
        test_restart();
        test_line_limit();
        test_random_traffic();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        for (int k = 0; k < 5000 && pending_verdicts.size() != 0; k++) @(posedge i_clk);
        if (pending_verdicts.size() != 0) begin
            report($sformatf("%0d result words never arrived", pending_verdicts.size()));
        end
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
